// File: design/sprite_quad_batch_setup_defines.svh
// ----------------------------------------------------------------------------
// Sprite quad batch setup: assertion macros
// Concurrent-assertion helpers used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_BATCH_SETUP_DEFINES_SVH
`define SPRITE_QUAD_BATCH_SETUP_DEFINES_SVH

// same-cycle implication
`define SQBS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqbs assertion failed");

// next-cycle implication
`define SQBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqbs assertion failed");

`endif

// File: design/sqbs_pkg.sv
// ----------------------------------------------------------------------------
// sqbs_pkg
// Types, constants and the CORDIC arctangent table for sprite quad setup.
// ----------------------------------------------------------------------------
package sqbs_pkg;

   localparam int BATCH_QUADS   = 1024;
   localparam int TEXTURE_SLOTS = 16;
   localparam int QUAD_W        = $clog2(BATCH_QUADS + 1);
   localparam int SNEXT_W       = $clog2(TEXTURE_SLOTS + 1);
   localparam int SLOT_W        = $clog2(TEXTURE_SLOTS);

   localparam int CORDIC_STEPS  = 18;
   localparam int STEP_W        = $clog2(CORDIC_STEPS);
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

   localparam logic MODE_DRAW   = 1'b0;
   localparam logic MODE_EOF    = 1'b1;
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [30:0]        width;
      logic [30:0]        height;
      logic [15:0]        angle;
      logic [31:0]        color;
      logic [15:0]        texture_id;
      logic [63:0]        uv_rect;
      logic [1:0]         flip;
   } sqbs_req_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic [31:0]        vertex_color;
      logic [3:0]         tex_slot;
      logic [15:0]        slot_texture;
      logic [10:0]        quad_count;
      logic [4:0]         slots_used;
      logic               last;
   } sqbs_rsp_type;

   typedef struct packed {
      logic              load_in;
      logic              restart;
      logic              emit_flush;
      logic              emit_vertex;
      logic              last;
      logic              resolve;
      logic              cordic_init;
      logic              cordic_step;
      logic              mul_step;
      logic              sum_step;
      logic [STEP_W-1:0] idx;
   } sqbs_cmd_type;

   typedef struct packed {
      logic is_eof;
      logic batch_full;
      logic quads_nz;
      logic tex_nz;
      logic hit;
      logic table_full;
      logic out_free;
   } sqbs_stat_type;

   // arctangent of 2^-i in 2^-24 turn units
   function automatic logic signed [24:0] atan_unit(input logic [STEP_W-1:0] i);
      logic signed [24:0] a;
      case (i)
         5'd0:    a = 25'sd2097152;
         5'd1:    a = 25'sd1238021;
         5'd2:    a = 25'sd654136;
         5'd3:    a = 25'sd332050;
         5'd4:    a = 25'sd166669;
         5'd5:    a = 25'sd83416;
         5'd6:    a = 25'sd41718;
         5'd7:    a = 25'sd20860;
         5'd8:    a = 25'sd10430;
         5'd9:    a = 25'sd5215;
         5'd10:   a = 25'sd2608;
         5'd11:   a = 25'sd1304;
         5'd12:   a = 25'sd652;
         5'd13:   a = 25'sd326;
         5'd14:   a = 25'sd163;
         5'd15:   a = 25'sd81;
         5'd16:   a = 25'sd41;
         5'd17:   a = 25'sd20;
         default: a = 25'sd0;
      endcase
      return a;
   endfunction

endpackage

// File: design/sprite_quad_batch_setup.sv
// ----------------------------------------------------------------------------
// sprite_quad_batch_setup
// Turns sprite draw beats into four-vertex quads and batch flush records.
// ----------------------------------------------------------------------------
// One item at a time. A draw beat goes through an intake step, a decision
// step (taken again after each flush record that must go out first), the
// shared CORDIC stage for sine and cosine, the single corner multiplier
// (w*cos, w*sin, h*cos, h*sin), then per vertex a corner sum, then translate
// and saturate into the output register. req_stall is high from the
// accepting edge until the last result has been loaded into the output
// register; result beats wait there under rsp_stall. Vertices come out
// bottom-left, bottom-right, top-right, top-left; last marks the final beat
// caused by an input. Texture slots are matched combinationally against a
// 15-entry register table; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "sprite_quad_batch_setup_defines.svh"

module sprite_quad_batch_setup
   import sqbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sqbs_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sqbs_rsp_type rsp_payload
);

   sqbs_cmd_type  cmd;
   sqbs_stat_type stat;

   // sequencer
   sqbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath and output register
   sqbs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a flush record never reports an empty batch
   `SQBS_ASSERT_IMPLY(a_flush_nonempty, clock, reset,
      rsp_valid && (rsp_payload.kind == KIND_FLUSH), rsp_payload.quad_count != '0)
   // busy right after a beat is taken
   `SQBS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // results only load into a free output register
   `SQBS_ASSERT_IMPLY(a_emit_when_free, clock, reset,
      cmd.emit_flush || cmd.emit_vertex, !(rsp_valid && rsp_stall))

endmodule

// File: design/sqbs_datapath.sv
// ----------------------------------------------------------------------------
// sqbs_datapath
// Batch state, slot table, CORDIC, corner multiplier and output register.
// ----------------------------------------------------------------------------
module sqbs_datapath
   import sqbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sqbs_req_type  req_payload,
   input  sqbs_cmd_type  cmd,
   output sqbs_stat_type stat,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output sqbs_rsp_type  rsp_payload
);

   localparam logic signed [36:0] SAT_MAX = 37'sh0_7FFF_FFFF;
   localparam logic signed [36:0] SAT_MIN = -37'sh0_8000_0000;
   localparam logic signed [67:0] ROUND_HALF = 68'sd1073741824;

   sqbs_req_type       item_ff;
   logic [15:0]        slot_table_ff [1:TEXTURE_SLOTS-1];
   logic [SNEXT_W-1:0] slot_next_ff, slot_next_in;
   logic [QUAD_W-1:0]  quads_ff, quads_in;
   logic [SLOT_W-1:0]  slot_ff;
   logic signed [33:0] x_ff, y_ff;
   logic signed [24:0] z_ff;
   logic               zero_r_ff;
   logic signed [65:0] prod_ff [0:3];
   logic signed [67:0] rx_ff, ry_ff;
   sqbs_rsp_type       out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               hit;
   logic [SLOT_W-1:0]  hit_idx;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX)      r = 32'sh7FFF_FFFF;
      else if (v < SAT_MIN) r = 32'sh8000_0000;
      else                  r = v[31:0];
      return r;
   endfunction

   // texture lookup over live slots, lowest slot wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int j = TEXTURE_SLOTS - 1; j >= 1; j--) begin
         if ((SNEXT_W'(j) < slot_next_ff) && (slot_table_ff[j] == item_ff.texture_id)) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(j);
         end
      end
   end

   assign stat.is_eof     = (item_ff.mode == MODE_EOF);
   assign stat.batch_full = (quads_ff >= QUAD_W'(BATCH_QUADS));
   assign stat.quads_nz   = (quads_ff != '0);
   assign stat.tex_nz     = (item_ff.texture_id != '0);
   assign stat.hit        = hit;
   assign stat.table_full = (slot_next_ff >= SNEXT_W'(TEXTURE_SLOTS));
   assign stat.out_free   = !out_valid_ff || !rsp_stall;

   // CORDIC step
   logic signed [33:0] dx, dy;
   logic signed [24:0] at;
   assign dx = y_ff >>> cmd.idx;
   assign dy = x_ff >>> cmd.idx;
   assign at = atan_unit(cmd.idx);

   // quadrant fold
   logic signed [33:0] bx, by, cos_v, sin_v;
   always_comb begin
      bx = zero_r_ff ? Q30_ONE : x_ff;
      by = zero_r_ff ? 34'sd0 : y_ff;
      case (item_ff.angle[15:14])
         2'd0:    begin cos_v = bx;  sin_v = by;  end
         2'd1:    begin cos_v = -by; sin_v = bx;  end
         2'd2:    begin cos_v = -bx; sin_v = -by; end
         default: begin cos_v = by;  sin_v = -bx; end
      endcase
   end

   // one shared multiplier: w*c, w*s, h*c, h*s
   logic signed [31:0] op_a;
   logic signed [33:0] op_b;
   logic signed [65:0] prod;
   assign op_a = cmd.idx[1] ? $signed({1'b0, item_ff.height}) : $signed({1'b0, item_ff.width});
   assign op_b = cmd.idx[0] ? sin_v : cos_v;
   assign prod = op_a * op_b;

   // corner sums with half-up rounding bias
   logic               wneg, hneg;
   logic signed [67:0] wc, ws, hc, hs, rx_in, ry_in;
   assign wneg = (cmd.idx[1:0] == 2'd0) || (cmd.idx[1:0] == 2'd3);
   assign hneg = !cmd.idx[1];
   assign wc = 68'(prod_ff[0]);
   assign ws = 68'(prod_ff[1]);
   assign hc = 68'(prod_ff[2]);
   assign hs = 68'(prod_ff[3]);
   assign rx_in = (wneg ? -wc : wc) - (hneg ? -hs : hs) + ROUND_HALF;
   assign ry_in = (wneg ? -ws : ws) + (hneg ? -hc : hc) + ROUND_HALF;

   // placement
   logic signed [36:0] vx, vy;
   assign vx = 37'(item_ff.pos_x) + 37'(rx_ff >>> 31);
   assign vy = 37'(item_ff.pos_y) + 37'(ry_ff >>> 31);

   // UV selection with flips
   logic [15:0] u0, v0, u1, v1, us, vs;
   always_comb begin
      u0 = item_ff.flip[0] ? item_ff.uv_rect[47:32] : item_ff.uv_rect[15:0];
      u1 = item_ff.flip[0] ? item_ff.uv_rect[15:0]  : item_ff.uv_rect[47:32];
      v0 = item_ff.flip[1] ? item_ff.uv_rect[63:48] : item_ff.uv_rect[31:16];
      v1 = item_ff.flip[1] ? item_ff.uv_rect[31:16] : item_ff.uv_rect[63:48];
      us = ((cmd.idx[1:0] == 2'd1) || (cmd.idx[1:0] == 2'd2)) ? u1 : u0;
      vs = cmd.idx[1] ? v1 : v0;
   end

   // batch counters
   always_comb begin
      slot_next_in = slot_next_ff;
      quads_in     = quads_ff;
      if (cmd.restart) begin
         slot_next_in = SNEXT_W'(1);
         quads_in     = '0;
      end else if (cmd.resolve) begin
         quads_in = quads_ff + QUAD_W'(1);
         if (stat.tex_nz && !hit) slot_next_in = slot_next_ff + SNEXT_W'(1);
      end
   end

   // output register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.emit_flush) begin
         out_in            = '0;
         out_in.kind       = KIND_FLUSH;
         out_in.quad_count = 11'(quads_ff);
         out_in.slots_used = 5'(slot_next_ff);
         out_in.last       = cmd.last;
         out_valid_in      = 1'b1;
      end else if (cmd.emit_vertex) begin
         out_in.kind         = KIND_VERTEX;
         out_in.vert_x       = sat32(vx);
         out_in.vert_y       = sat32(vy);
         out_in.tex_u        = us;
         out_in.tex_v        = vs;
         out_in.vertex_color = item_ff.color;
         out_in.tex_slot     = 4'(slot_ff);
         out_in.slot_texture = (slot_ff != '0) ? item_ff.texture_id : 16'h0000;
         out_in.quad_count   = '0;
         out_in.slots_used   = '0;
         out_in.last         = cmd.last;
         out_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_next_ff <= SNEXT_W'(1);
         quads_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_next_ff <= slot_next_in;
         quads_ff     <= quads_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (cmd.load_in) item_ff <= req_payload;
      if (cmd.resolve) begin
         if (!stat.tex_nz)  slot_ff <= '0;
         else if (hit)      slot_ff <= hit_idx;
         else begin
            slot_ff <= slot_next_ff[SLOT_W-1:0];
            slot_table_ff[slot_next_ff[SLOT_W-1:0]] <= item_ff.texture_id;
         end
      end
      if (cmd.cordic_init) begin
         x_ff      <= CORDIC_GAIN;
         y_ff      <= '0;
         z_ff      <= 25'({item_ff.angle[13:0], 8'h00});
         zero_r_ff <= (item_ff.angle[13:0] == '0);
      end else if (cmd.cordic_step) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
      end
      if (cmd.mul_step) prod_ff[cmd.idx[1:0]] <= prod;
      if (cmd.sum_step) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// File: design/sqbs_ctrl.sv
// ----------------------------------------------------------------------------
// sqbs_ctrl
// Sequencer: intake, flush decisions, CORDIC, multiply and vertex emission.
// ----------------------------------------------------------------------------
module sqbs_ctrl
   import sqbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  sqbs_stat_type stat,
   output sqbs_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_CORDIC = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              need_restart, need_flush;

   assign req_stall    = reset || (state_ff != ST_IDLE);
   assign need_restart = stat.is_eof || stat.batch_full ||
                         (stat.tex_nz && !stat.hit && stat.table_full);
   assign need_flush   = need_restart && stat.quads_nz;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.idx  = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load_in = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (need_restart) begin
               if (!need_flush || stat.out_free) begin
                  cmd.restart    = 1'b1;
                  cmd.emit_flush = need_flush;
                  cmd.last       = stat.is_eof;
                  if (stat.is_eof) state_in = ST_IDLE;
               end
            end else begin
               cmd.resolve     = 1'b1;
               cmd.cordic_init = 1'b1;
               cnt_in          = '0;
               state_in        = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == STEP_W'(3)) begin
               cnt_in   = '0;
               state_in = ST_SUM;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_vertex = 1'b1;
               cmd.last        = (cnt_ff == STEP_W'(3));
               if (cnt_ff == STEP_W'(3)) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + STEP_W'(1);
                  state_in = ST_SUM;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sprite_quad_batch_setup. Draw and end-of-frame
// beats go in through the request channel and every vertex and flush beat is
// checked against a local model of the quad, texture slot and batch logic.
// ----------------------------------------------------------------------------
module tb_top;
   import sqbs_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side
   localparam int TAIL_CYCLES    = 60;

   // arctangent of 2^-i in 2^-24 turn units
   localparam longint ATAN_TURNS [18] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
      5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   sqbs_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   sqbs_rsp_type rsp_payload;

   sprite_quad_batch_setup DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // --- local copy of the batch state --------------------------------------
   logic [15:0]  bound_tex [TEXTURE_SLOTS];
   int           next_slot = 1;
   int           quads_in_batch = 0;
   sqbs_rsp_type pending_beats [$];

   // run statistics and idling controls
   int errors = 0;
   int items_sent = 0;
   int vertices_seen = 0;
   int flushes_seen = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;         // no gaps and no stalls while set
   int long_hold_req = 0;   // receiver hold-off requested by a test

   // --- predictor -----------------------------------------------------------
   function automatic void queue_beat(sqbs_rsp_type b);
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   function automatic void push_flush(logic is_last);
      sqbs_rsp_type f;
      if (quads_in_batch > 0) begin
         f = '0;
         f.kind       = KIND_FLUSH;
         f.quad_count = 11'(quads_in_batch);
         f.slots_used = 5'(next_slot);
         f.last       = is_last;
         queue_beat(f);
      end
      quads_in_batch = 0;
      next_slot = 1;
   endfunction

   // Q1.30 cosine and sine, CORDIC within the quadrant
   function automatic void sincos_q30(input logic [15:0] ang, output longint c,
                                      output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(ang[13:0]) <<< 8;
      if (ang[13:0] == 0) begin
         x = 1073741824;
      end else begin
         for (int i = 0; i < 18; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ATAN_TURNS[i];
            end else begin
               x += dx; y -= dy; z += ATAN_TURNS[i];
            end
         end
      end
      case (ang[15:14])
         2'd0:    begin c = x;  s = y;  end
         2'd1:    begin c = -y; s = x;  end
         2'd2:    begin c = -x; s = -y; end
         default: begin c = y;  s = -x; end
      endcase
   endfunction

   // round the Q.47 offset to Q16.16, add the centre and saturate
   function automatic logic [31:0] translate_sat(longint q47, logic signed [31:0] centre);
      longint v;
      v = longint'(centre) + ((q47 + (64'sd1 <<< 30)) >>> 31);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic void predict_quad(sqbs_req_type r);
      sqbs_rsp_type vtx;
      int slot;
      bit found;
      longint w, h, c, s, rx, ry;
      longint cx [4], cy [4];
      logic [15:0] u0, v0, u1, v1, t;
      logic [15:0] us [4], vs [4];
      slot = 0;
      found = 1'b0;
      if (r.mode == MODE_EOF) begin
         push_flush(1'b1);
         return;
      end
      if (quads_in_batch >= BATCH_QUADS) push_flush(1'b0);
      if (r.texture_id != 0) begin
         for (int j = 1; j < next_slot && j < TEXTURE_SLOTS; j++) begin
            if (!found && bound_tex[j] == r.texture_id) begin
               slot = j;
               found = 1'b1;
            end
         end
         if (!found) begin
            if (next_slot >= TEXTURE_SLOTS) push_flush(1'b0);
            slot = next_slot;
            bound_tex[slot] = r.texture_id;
            next_slot++;
         end
      end
      sincos_q30(r.angle, c, s);
      w = longint'(r.width);
      h = longint'(r.height);
      cx = '{-w, w, w, -w};
      cy = '{-h, -h, h, h};
      u0 = r.uv_rect[15:0];  v0 = r.uv_rect[31:16];
      u1 = r.uv_rect[47:32]; v1 = r.uv_rect[63:48];
      if (r.flip[0]) begin t = u0; u0 = u1; u1 = t; end
      if (r.flip[1]) begin t = v0; v0 = v1; v1 = t; end
      us = '{u0, u1, u1, u0};
      vs = '{v0, v0, v1, v1};
      for (int i = 0; i < 4; i++) begin
         rx = cx[i] * c - cy[i] * s;
         ry = cx[i] * s + cy[i] * c;
         vtx = '0;
         vtx.kind         = KIND_VERTEX;
         vtx.vert_x       = translate_sat(rx, r.pos_x);
         vtx.vert_y       = translate_sat(ry, r.pos_y);
         vtx.tex_u        = us[i];
         vtx.tex_v        = vs[i];
         vtx.vertex_color = r.color;
         vtx.tex_slot     = 4'(slot);
         vtx.slot_texture = (slot != 0) ? bound_tex[slot] : 16'd0;
         vtx.last         = (i == 3);
         queue_beat(vtx);
      end
      quads_in_batch++;
   endfunction

   // --- idling --------------------------------------------------------------
   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 65) return 0;
      if (p < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls, plus the long hold-off a test may ask for
   int stall_left = 0;
   always @(negedge clock) begin
      if (long_hold_req > 0) begin
         stall_left = long_hold_req;
         long_hold_req = 0;
      end else if (stall_left == 0) begin
         stall_left = idle_len();
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // --- sender --------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after the accepting
   // rising edge, with the expectations already queued. valid drops at the
   // accepting rising edge, so an accepted payload is never offered again.
   task automatic send_beat(sqbs_req_type r);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
      predict_quad(r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      drop_valid();
      wait (pending_beats.size() == 0);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // --- checker -------------------------------------------------------------
   task automatic report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      sqbs_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            report("unexpected beat", '0, 64'(rsp_payload.vert_x));
         end else begin
            e = pending_beats.pop_front();
            if (e.kind == KIND_FLUSH) flushes_seen++; else vertices_seen++;
            if (rsp_payload.kind != e.kind)
               report("kind", 64'(e.kind), 64'(rsp_payload.kind));
            if (rsp_payload.vert_x != e.vert_x)
               report("vert_x", 64'(e.vert_x), 64'(rsp_payload.vert_x));
            if (rsp_payload.vert_y != e.vert_y)
               report("vert_y", 64'(e.vert_y), 64'(rsp_payload.vert_y));
            if (rsp_payload.tex_u != e.tex_u)
               report("tex_u", 64'(e.tex_u), 64'(rsp_payload.tex_u));
            if (rsp_payload.tex_v != e.tex_v)
               report("tex_v", 64'(e.tex_v), 64'(rsp_payload.tex_v));
            if (rsp_payload.vertex_color != e.vertex_color)
               report("vertex_color", 64'(e.vertex_color), 64'(rsp_payload.vertex_color));
            if (rsp_payload.tex_slot != e.tex_slot)
               report("tex_slot", 64'(e.tex_slot), 64'(rsp_payload.tex_slot));
            if (rsp_payload.slot_texture != e.slot_texture)
               report("slot_texture", 64'(e.slot_texture), 64'(rsp_payload.slot_texture));
            if (rsp_payload.quad_count != e.quad_count)
               report("quad_count", 64'(e.quad_count), 64'(rsp_payload.quad_count));
            if (rsp_payload.slots_used != e.slots_used)
               report("slots_used", 64'(e.slots_used), 64'(rsp_payload.slots_used));
            if (rsp_payload.last != e.last)
               report("last", 64'(e.last), 64'(rsp_payload.last));
         end
      end
   end

   // watchdog: a stretch with no beat on either channel ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d idle cycles, %0d beats still due",
                  idle_cycles, pending_beats.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // --- item builders -------------------------------------------------------
   // biased toward the ends of the range so saturation gets hit
   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return $urandom_range(0, 32'h0040_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(0, 3)) << 14;
         1:       return 16'($urandom_range(0, 7)) << 13;
         default: return 16'($urandom());
      endcase
   endfunction

   // textures mostly from a small pool so slots get reused and the table fills
   function automatic logic [15:0] pick_texture();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'($urandom());
         2:       return 16'hFFFF;
         default: return 16'($urandom_range(1, 22));
      endcase
   endfunction

   function automatic sqbs_req_type draw_item(logic [15:0] tex);
      sqbs_req_type r;
      r.mode       = MODE_DRAW;
      r.pos_x      = pick32();
      r.pos_y      = pick32();
      r.width      = 31'(pick32());
      r.height     = 31'(pick32());
      r.angle      = pick_angle();
      r.color      = $urandom();
      r.texture_id = tex;
      r.uv_rect    = {pick32(), pick32()};
      r.flip       = 2'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic sqbs_req_type eof_item();
      sqbs_req_type r;
      r = draw_item(pick_texture());  // fields are ignored on end of frame
      r.mode = MODE_EOF;
      return r;
   endfunction

   // --- tests ---------------------------------------------------------------
   // corner cases: extremes, every quadrant, flips, texture 0, empty frame end
   task automatic test_directed();
      sqbs_req_type r;
      send_beat(eof_item());                       // empty batch: nothing out
      r = draw_item(16'd0);
      r.pos_x = '0; r.pos_y = '0; r.width = '0; r.height = '0; r.angle = '0;
      r.flip = 2'd0;
      send_beat(r);                                // degenerate quad
      for (int q = 0; q < 4; q++) begin
         r = draw_item(16'd5);                     // same texture: slot hit
         r.pos_x = 32'sd65536; r.pos_y = -32'sd65536;
         r.width = 31'h0002_0000; r.height = 31'h0001_0000;
         r.angle = 16'(q) << 14;
         r.flip = 2'(q);
         send_beat(r);
      end
      r = draw_item(16'hFFFF);
      r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h8000_0000;
      r.width = 31'h7FFF_FFFF; r.height = 31'h7FFF_FFFF;
      r.angle = 16'h2000; r.uv_rect = '1;
      send_beat(r);                                // saturates both ways
      r.pos_x = 32'h8000_0000; r.pos_y = 32'h7FFF_FFFF; r.angle = 16'hFFFF;
      r.uv_rect = 64'h0123_4567_89AB_CDEF; r.flip = 2'd3;
      send_beat(r);
      r.angle = 16'h6000; r.color = 32'hFFFF_FFFF; r.texture_id = 16'd1;
      send_beat(r);
      send_beat(eof_item());                       // flush with last set
      send_beat(eof_item());                       // empty again
   endtask

   // four new textures more than the table holds force a mid-frame flush
   task automatic test_slot_overflow();
      for (int t = 0; t < TEXTURE_SLOTS + 3; t++) send_beat(draw_item(16'(100 + t)));
      send_beat(draw_item(16'd100));               // rebound after restart
      send_beat(eof_item());
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      long_hold_req = 300;
      for (int n = 0; n < 8; n++) send_beat(draw_item(pick_texture()));
      // sender pauses until every due beat has come back
      wait_drained();
      for (int n = 0; n < 4; n++) send_beat(draw_item(pick_texture()));
      wait_drained();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 4) send_beat(eof_item());
         else send_beat(draw_item(pick_texture()));
      end
      calm = 1'b0;
      send_beat(eof_item());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_slot_overflow();
      test_backpressure();
      test_random(336);
      wait_drained();
      $display("covered %0d input beats: %0d vertices and %0d flushes checked",
               items_sent, vertices_seen, flushes_seen);
      $display("including slot table overflow, quadrant and saturation corners, long hold-off");
      if (errors == 0 && pending_beats.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("%0d mismatches, %0d beats never came", errors, pending_beats.size());
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// File: sprite_quad_batch_setup.f
+incdir+design
design/sqbs_pkg.sv
design/sqbs_datapath.sv
design/sqbs_ctrl.sv
design/sprite_quad_batch_setup.sv
sim/tb_top.sv
